// File: sv/b64lw_pkg.sv
// Shared types, constants and the Base64 alphabet for the line-wrapping encoder.
// No dependencies.
package b64lw_pkg;

  localparam int CHAR_W     = 7;
  localparam int BYTE_W     = 8;
  localparam int SEXTET_W   = 6;
  localparam int LINE_W     = 8;
  localparam int MAX_CHARS  = 6;
  localparam int CNT_W      = 3;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [LINE_W-1:0] LINE_BYTES_RST = 8'd57;

  localparam logic [CHAR_W-1:0] CH_PAD = 7'd61;
  localparam logic [CHAR_W-1:0] CH_CR  = 7'd13;
  localparam logic [CHAR_W-1:0] CH_LF  = 7'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRAP_ENABLE = 1'b0,
    CFG_LINE_BYTES  = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_t;

  // One queued request: up to six characters caused by one input byte.
  typedef struct packed {
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
    logic [CNT_W-1:0]                 last_idx;
    logic                             msg_last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [CHAR_W-1:0] b64_char(input logic [SEXTET_W-1:0] v);
    logic [CHAR_W-1:0] v7;
    logic [CHAR_W-1:0] ch;
    v7 = {1'b0, v};
    if (v < 6'd26)      ch = 7'd65 + v7;
    else if (v < 6'd52) ch = 7'd71 + v7;
    else if (v < 6'd62) ch = v7 - 7'd4;
    else if (v == 6'd62) ch = 7'd43;
    else                ch = 7'd47;
    return ch;
  endfunction

endpackage

// File: sv/b64lw_stream_if.sv
// Valid/ready stream interfaces for the input bytes and the output characters.
// Depends on b64lw_pkg.
interface b64lw_in_if;
  import b64lw_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface b64lw_out_if;
  import b64lw_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              run_last;
  logic              message_end;
  modport source (output valid, out_char, run_last, message_end, input ready);
  modport sink   (input valid, out_char, run_last, message_end, output ready);
endinterface

// File: sv/b64lw_front.sv
// Front end: config registers, byte intake, group/line state and request build.
// Depends on b64lw_pkg and b64lw_stream_if.
module b64lw_front
  import b64lw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  b64lw_in_if.sink              in_ch,
  input  q_stat_t               q_stat,
  output logic                  q_push,
  output job_t                  q_job
);

  logic              wrap_enable_r;
  logic [LINE_W-1:0] line_bytes_r;
  phase_t            phase_r, phase_nxt;
  logic [SEXTET_W-1:0] carry_r, carry_nxt;
  logic [LINE_W-1:0] line_count_r, line_count_nxt;

  logic [BYTE_W-1:0]   b;
  logic                last;
  logic [LINE_W-1:0]   lc_inc;
  logic                hit;
  logic [CNT_W-1:0]    n;
  logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
  phase_t              grp_phase;
  logic [SEXTET_W-1:0] grp_carry;

  assign in_ch.ready = !q_stat.full;
  assign q_push      = in_ch.valid && !q_stat.full;
  assign b           = in_ch.data_byte;
  assign last        = in_ch.last_byte;
  assign lc_inc      = line_count_r + 8'd1;
  assign hit         = (lc_inc == line_bytes_r);

  always_comb begin
    chars     = '0;
    n         = '0;
    grp_phase = PH_0;
    grp_carry = '0;
    unique case (phase_r)
      PH_0: begin
        chars[0]  = b64_char(b[7:2]);
        grp_carry = {b[1:0], 4'b0000};
        grp_phase = PH_1;
        n         = 3'd1;
      end
      PH_1: begin
        chars[0]  = b64_char(carry_r | {2'b00, b[7:4]});
        grp_carry = {b[3:0], 2'b00};
        grp_phase = PH_2;
        n         = 3'd1;
      end
      default: begin
        chars[0] = b64_char(carry_r | {4'b0000, b[7:6]});
        chars[1] = b64_char(b[5:0]);
        n        = 3'd2;
      end
    endcase
    if (hit && wrap_enable_r && !last) begin
      chars[n] = CH_CR;
      n        = n + 3'd1;
      chars[n] = CH_LF;
      n        = n + 3'd1;
    end
    if (last) begin
      if (grp_phase != PH_0) begin
        chars[n] = b64_char(grp_carry);
        n        = n + 3'd1;
        if (grp_phase == PH_1) begin
          chars[n] = CH_PAD;
          n        = n + 3'd1;
        end
        chars[n] = CH_PAD;
        n        = n + 3'd1;
      end
      if (wrap_enable_r) begin
        chars[n] = CH_CR;
        n        = n + 3'd1;
        chars[n] = CH_LF;
        n        = n + 3'd1;
      end
    end
    q_job.chars    = chars;
    q_job.last_idx = n - 3'd1;
    q_job.msg_last = last;
  end

  always_comb begin
    if (last) begin
      phase_nxt      = PH_0;
      carry_nxt      = '0;
      line_count_nxt = '0;
    end else begin
      phase_nxt      = grp_phase;
      carry_nxt      = grp_carry;
      line_count_nxt = hit ? '0 : lc_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_enable_r <= 1'b1;
      line_bytes_r  <= LINE_BYTES_RST;
      phase_r       <= PH_0;
      carry_r       <= '0;
      line_count_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_WRAP_ENABLE: wrap_enable_r <= cfg_wdata[0];
          CFG_LINE_BYTES:  line_bytes_r  <= cfg_wdata[LINE_W-1:0];
        endcase
      end
      if (q_push) begin
        phase_r      <= phase_nxt;
        carry_r      <= carry_nxt;
        line_count_r <= line_count_nxt;
      end
    end
  end

endmodule

// File: sv/b64lw_queue.sv
// Short FIFO of character requests between front and back end.
// Depends on b64lw_pkg.
module b64lw_queue
  import b64lw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  job_t              entries_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]     count_r, count_nxt;

  assign stat.full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// File: sv/b64lw_back.sv
// Back end: walks the head request one character a cycle, while the output is not stalled, into the output register.
// Depends on b64lw_pkg and b64lw_stream_if.
module b64lw_back
  import b64lw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head,
  input  q_stat_t   q_stat,
  output logic      pop,
  b64lw_out_if.source out_ch
);

  logic [CNT_W-1:0]  idx_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              run_last_r;
  logic              message_end_r;
  logic              load;
  logic              at_end;

  assign load   = !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign at_end = (idx_r == head.last_idx);
  assign pop    = load && at_end;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_char    = out_char_r;
  assign out_ch.run_last    = run_last_r;
  assign out_ch.message_end = message_end_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r    <= head.chars[idx_r];
      run_last_r    <= at_end;
      message_end_r <= at_end && head.msg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= at_end ? '0 : idx_r + 3'd1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: sv/base64_line_wrapping_encoder_unit.sv
// Channel  Dir  Handshake          Payload
// in_ch    in   valid/ready        data_byte[7:0], last_byte
// out_ch   out  valid/ready        out_char[6:0], run_last, message_end
// cfg      in   cfg_we (write)     cfg_index[0], cfg_wdata[7:0]
// Each byte becomes a request of 1 to 6 characters, queued 4 deep.
// A byte is taken in the cycle it arrives while the queue has room.
// The output register sends one character a cycle while out_ch is ready.
// Synchronous active-low reset; no clearing pass. Either side may stall.
// Top level of the Base64 line-wrapping encoder: front, queue, back.
// Depends on b64lw_pkg, b64lw_stream_if, b64lw_front, b64lw_queue, b64lw_back.
module base64_line_wrapping_encoder_unit
  import b64lw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  b64lw_in_if.sink              in_ch,
  b64lw_out_if.source           out_ch
);

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  job_t    q_job;
  job_t    q_head;

  b64lw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  b64lw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  b64lw_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .q_stat (q_stat),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.message_end) |-> out_ch.run_last)
    else $error("message end without run end");

  a_req_len: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_job.last_idx < 3'(MAX_CHARS)))
    else $error("request longer than six characters");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for base64_line_wrapping_encoder_unit: directed table, then random
// messages per register setting, with idle/stall mixes on both channels.
// Depends on b64lw_pkg and the b64lw_in_if / b64lw_out_if interfaces.
module tb_top;
  import b64lw_pkg::*;

  localparam int RUN_LIMIT = 400000;
  localparam int NUM_DIR   = 25;
  localparam logic [8*64-1:0] B64_ALPHABET =
    {"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdef", "ghijklmnopqrstuvwxyz0123456789+/"};

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    cfg_idx_t           idx;
    logic [BYTE_W-1:0]  val;
    logic               lst;
    logic [2:0]         exp_n;
    logic [8*MAX_CHARS-1:0] exp_txt;
  } dir_row_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              run_last;
    logic              msg_end;
  } enc_char_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  b64lw_in_if  in_ch ();
  b64lw_out_if out_ch ();

  base64_line_wrapping_encoder_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // encoder model state
  logic              wrap_en_m;
  logic [LINE_W-1:0] line_len_m;
  phase_t            phase_m;
  logic [5:0]        carry_m;
  logic [LINE_W-1:0] line_cnt_m;
  logic [CHAR_W-1:0] enc_buf [MAX_CHARS];
  int                enc_cnt;

  enc_char_t pending_chars [$];
  dir_row_t  dir_rows [NUM_DIR];

  logic [2:0]             typed_n;
  logic [8*MAX_CHARS-1:0] typed_txt;
  int src_idle_pct;
  int snk_stall_pct;
  int n_errors;
  int n_bytes;
  int n_chars;
  int n_reg_writes;
  int cycle_cnt;

  function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] v);
    int pos;
    pos = 63 - int'(v);
    return B64_ALPHABET[8*pos +: CHAR_W];
  endfunction

  task automatic emit(input logic [CHAR_W-1:0] c);
    enc_buf[enc_cnt] = c;
    enc_cnt++;
  endtask

  task automatic encode_byte(input logic [BYTE_W-1:0] b, input logic lst);
    enc_cnt = 0;
    case (phase_m)
      PH_0: begin
        emit(sextet_char(b[7:2]));
        carry_m = {b[1:0], 4'b0};
        phase_m = PH_1;
      end
      PH_1: begin
        emit(sextet_char(carry_m | {2'b0, b[7:4]}));
        carry_m = {b[3:0], 2'b0};
        phase_m = PH_2;
      end
      default: begin
        emit(sextet_char(carry_m | {4'b0, b[7:6]}));
        emit(sextet_char(b[5:0]));
        carry_m = '0;
        phase_m = PH_0;
      end
    endcase
    line_cnt_m = line_cnt_m + 8'd1;
    if (line_cnt_m == line_len_m) begin
      line_cnt_m = '0;
      if (wrap_en_m && !lst) begin
        emit(CH_CR);
        emit(CH_LF);
      end
    end
    if (lst) begin
      if (phase_m != PH_0) begin
        emit(sextet_char(carry_m));
        if (phase_m == PH_1) emit(CH_PAD);
        emit(CH_PAD);
      end
      if (wrap_en_m) begin
        emit(CH_CR);
        emit(CH_LF);
      end
      phase_m = PH_0;
      carry_m = '0;
      line_cnt_m = '0;
    end
  endtask

  function automatic dir_row_t byte_row(input logic [7:0] v, input logic l,
                                        input logic [2:0] n, input logic [47:0] txt);
    dir_row_t row;
    row = '0;
    row.kind = ROW_BYTE;
    row.val = v;
    row.lst = l;
    row.exp_n = n;
    row.exp_txt = txt;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input cfg_idx_t idx, input logic [7:0] v);
    dir_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.val = v;
    return row;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(7, 0))
      0: return 8'h00;
      1: return 8'hFF;
      default: return BYTE_W'($urandom_range(255, 0));
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: run limit of %0d cycles reached, %0d chars outstanding",
             $time, RUN_LIMIT, pending_chars.size());
    $display("tb_top failed");
    $finish;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99, 0) >= snk_stall_pct);
  end

  // request/result tracking and compare
  always @(posedge clk) begin
    enc_char_t item;
    enc_char_t got;
    int cnt;
    if (!rst_n) begin
      wrap_en_m  = 1'b1;
      line_len_m = LINE_BYTES_RST;
      phase_m    = PH_0;
      carry_m    = '0;
      line_cnt_m = '0;
    end else begin
      if (cfg_we) begin
        n_reg_writes++;
        case (cfg_index)
          CFG_WRAP_ENABLE: wrap_en_m = cfg_wdata[0];
          CFG_LINE_BYTES:  line_len_m = cfg_wdata[LINE_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        encode_byte(in_ch.data_byte, in_ch.last_byte);
        n_bytes++;
        cnt = (typed_n != 0) ? int'(typed_n) : enc_cnt;
        for (int i = 0; i < cnt; i++) begin
          item.ch = (typed_n != 0) ? typed_txt[8*(cnt-1-i) +: CHAR_W] : enc_buf[i];
          item.run_last = (i == cnt - 1);
          item.msg_end = (i == cnt - 1) && in_ch.last_byte;
          pending_chars.push_back(item);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got.ch = out_ch.out_char;
        got.run_last = out_ch.run_last;
        got.msg_end = out_ch.message_end;
        n_chars++;
        if (pending_chars.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected char: expected none, got %h run_last %b end %b",
                   $time, got.ch, got.run_last, got.msg_end);
        end else begin
          item = pending_chars.pop_front();
          if (got !== item) begin
            n_errors++;
            $display("%0t: mismatch: expected char %h run_last %b end %b, got %h %b %b",
                     $time, item.ch, item.run_last, item.msg_end,
                     got.ch, got.run_last, got.msg_end);
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // close_msg = 0 leaves the message open so it runs on under the next setting
  task automatic run_phase(input logic wrap, input int line, input int min_len,
                           input int max_len, input int n_items, input logic close_msg,
                           input int src_pct, input int snk_pct);
    int sent;
    int len;
    logic lst;
    wait_drained();
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    write_reg(CFG_WRAP_ENABLE, {7'd0, wrap});
    write_reg(CFG_LINE_BYTES, line[7:0]);
    sent = 0;
    while (sent < n_items) begin
      if (min_len == 1 && $urandom_range(3, 0) == 0)
        len = $urandom_range(3, 1);
      else if (min_len == 1 && line > 0 && line < 40 && $urandom_range(2, 0) == 0)
        len = line * $urandom_range(2, 1);
      else
        len = $urandom_range(max_len, min_len);
      for (int i = 0; i < len && sent < n_items; i++) begin
        lst = (i == len - 1);
        if (sent == n_items - 1) lst = close_msg;
        send_byte(rand_byte(), lst);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_WRAP_ENABLE;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    typed_n         = '0;
    typed_txt       = '0;
    src_idle_pct    = 29;
    snk_stall_pct   = 29;
    n_errors        = 0;
    n_bytes         = 0;
    n_chars         = 0;
    n_reg_writes    = 0;

    dir_rows[0]  = byte_row(8'h00, 1'b1, 3'd6, "AA==\r\n");
    dir_rows[1]  = byte_row(8'hFF, 1'b0, 3'd1, "/");
    dir_rows[2]  = byte_row(8'hFF, 1'b0, 3'd1, "/");
    dir_rows[3]  = byte_row(8'hFF, 1'b1, 3'd4, "//\r\n");
    dir_rows[4]  = byte_row(8'h4D, 1'b0, 3'd1, "T");
    dir_rows[5]  = byte_row(8'h61, 1'b0, 3'd1, "W");
    dir_rows[6]  = byte_row(8'h6E, 1'b1, 3'd4, "Fu\r\n");
    dir_rows[7]  = cfg_row(CFG_WRAP_ENABLE, 8'hFE);   // upper bits dropped: wrap off
    dir_rows[8]  = byte_row(8'h00, 1'b1, 3'd4, "AA==");
    dir_rows[9]  = byte_row(8'hFF, 1'b0, 3'd0, '0);
    dir_rows[10] = byte_row(8'h80, 1'b1, 3'd0, '0);
    dir_rows[11] = cfg_row(CFG_WRAP_ENABLE, 8'h01);
    dir_rows[12] = cfg_row(CFG_LINE_BYTES, 8'h01);    // every byte fills a line
    dir_rows[13] = byte_row(8'h12, 1'b0, 3'd0, '0);
    dir_rows[14] = byte_row(8'h34, 1'b0, 3'd0, '0);
    dir_rows[15] = byte_row(8'h56, 1'b1, 3'd0, '0);   // line full on last byte
    dir_rows[16] = byte_row(8'hAB, 1'b0, 3'd0, '0);
    dir_rows[17] = byte_row(8'hCD, 1'b1, 3'd0, '0);   // full line plus padded tail
    dir_rows[18] = cfg_row(CFG_LINE_BYTES, 8'hFF);
    dir_rows[19] = byte_row(8'h3C, 1'b0, 3'd0, '0);
    dir_rows[20] = cfg_row(CFG_LINE_BYTES, 8'h02);    // change inside a message
    dir_rows[21] = byte_row(8'hC3, 1'b0, 3'd0, '0);
    dir_rows[22] = byte_row(8'h00, 1'b1, 3'd0, '0);
    dir_rows[23] = cfg_row(CFG_LINE_BYTES, 8'h00);    // zero length means 256
    dir_rows[24] = byte_row(8'h7E, 1'b1, 3'd0, '0);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < NUM_DIR; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_drained();
        write_reg(dir_rows[r].idx, dir_rows[r].val);
      end else begin
        typed_n   = dir_rows[r].exp_n;
        typed_txt = dir_rows[r].exp_txt;
        send_byte(dir_rows[r].val, dir_rows[r].lst);
      end
    end
    typed_n = '0;

    run_phase(1'b1, 57, 1, 70, 60, 1'b1, 0, 0);
    run_phase(1'b1, 5, 1, 12, 50, 1'b0, 76, 0);
    run_phase(1'b0, 7, 1, 20, 50, 1'b1, 0, 76);
    run_phase(1'b1, 1, 1, 6, 40, 1'b1, 29, 29);
    run_phase(1'b0, 2, 1, 10, 30, 1'b1, 0, 0);
    run_phase(1'b1, 255, 1, 20, 20, 1'b1, 76, 0);
    run_phase(1'b1, 0, 1, 10, 10, 1'b1, 0, 0);

    wait_drained();
    repeat (16) @(negedge clk);

    $display("Sent %0d bytes, checked %0d characters after %0d register writes,",
             n_bytes, n_chars, n_reg_writes);
    $display("wrap on and off, line settings 0 to 255, idle and stall mixes; %0d errors.",
             n_errors);
    if (n_errors == 0 && pending_chars.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
